@@ rtl/core/lfcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfcr_pkg - LED flash current regulator shared definitions
// Mode encoding, register map and reset values used by the regulator core.
// ----------------------------------------------------------------------------
package lfcr_pkg;

    // Booster mode machine
    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_ON   = 2'd2,
        MODE_OFF  = 2'd3
    } mode_t;

    // Register map (word index, byte address is 4 * index)
    localparam int unsigned ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_TARGET_CURRENT = 3'd0,
        REG_TICKS_PER_MS   = 3'd1,
        REG_ON_TIME_MS     = 3'd2,
        REG_OFF_TIME_MS    = 3'd3,
        REG_WIDTH_START    = 3'd4,
        REG_WIDTH_MIN      = 3'd5,
        REG_WIDTH_MAX      = 3'd6,
        REG_NONE           = 3'd7
    } reg_idx_t;

    // Field widths
    localparam int unsigned CUR_W    = 10;
    localparam int unsigned PRE_W    = 5;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned WIDTH_W  = 8;

    // Reset values
    localparam logic [CUR_W-1:0]    RST_TARGET_CURRENT = 10'd730;
    localparam logic [PRE_W-1:0]    RST_TICKS_PER_MS   = 5'd25;
    localparam logic [PERIOD_W-1:0] RST_ON_TIME_MS     = 10'd50;
    localparam logic [PERIOD_W-1:0] RST_OFF_TIME_MS    = 10'd950;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH_START    = 8'd160;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH_MIN      = 8'd80;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH_MAX      = 8'd240;

endpackage

@@ rtl/core/led_flash_current_regulator.sv @@
// ----------------------------------------------------------------------------
// led_flash_current_regulator - LED flash booster current regulator
// Per-tick pulse width regulation with a millisecond on/off mode machine.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per base tick, carrying a coil current
//   sample. m_* channel: exactly one result transaction per input tick
//   (pulse fire flag, pulse width, LED on flag, millisecond event flag).
//   The APB port programs setpoint, prescale, on/off times and width limits;
//   write it only while no tick is in flight.
//   The result is registered and appears in the cycle after its tick is accepted.
//   Throughput: one tick per cycle while the receiver takes each result; the regulator state and the result
//   register are both updated by a single stage of compare/increment logic.
//   When the receiver stalls, the result register holds its transaction and
//   s_tready falls until the result is taken; a new tick is accepted in the
//   same cycle the held result leaves.
//   Reset (aresetn low, synchronous) restores the configuration and regulator state registers to their
//   defaults, puts the mode machine in init with the booster off, and
//   empties the result register.
// ----------------------------------------------------------------------------
module led_flash_current_regulator
    import lfcr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Input ticks
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [9:0] current_sample, [15:10] zero
    // Results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [0] pulse_fire, [8:1] pulse_width,
                                          // [9] led_on, [10] ms_event, rest zero
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [CUR_W-1:0]    target_current_reg;
    logic [PRE_W-1:0]    ticks_per_ms_reg;
    logic [PERIOD_W-1:0] on_time_ms_reg;
    logic [PERIOD_W-1:0] off_time_ms_reg;
    logic [WIDTH_W-1:0]  width_start_reg;
    logic [WIDTH_W-1:0]  width_min_reg;
    logic [WIDTH_W-1:0]  width_max_reg;

    // Regulator state
    mode_t               mode_reg, mode_next;
    logic                active_reg, active_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [PRE_W-1:0]    prescale_reg, prescale_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    // Result register
    logic                out_valid_reg;
    logic [15:0]         out_data_reg, out_data_next;

    logic                cfg_wr;
    reg_idx_t            cfg_idx;
    logic                in_acc;
    logic [CUR_W-1:0]    sample;
    logic [WIDTH_W-1:0]  w_step;
    logic [WIDTH_W-1:0]  w_clamp;
    logic                ms_evt;
    logic [PRE_W-1:0]    pre_base;
    logic [PERIOD_W-1:0] period_dec;

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_current_reg <= RST_TARGET_CURRENT;
            ticks_per_ms_reg   <= RST_TICKS_PER_MS;
            on_time_ms_reg     <= RST_ON_TIME_MS;
            off_time_ms_reg    <= RST_OFF_TIME_MS;
            width_start_reg    <= RST_WIDTH_START;
            width_min_reg      <= RST_WIDTH_MIN;
            width_max_reg      <= RST_WIDTH_MAX;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TARGET_CURRENT: target_current_reg <= pwdata[CUR_W-1:0];
                REG_TICKS_PER_MS:   ticks_per_ms_reg   <= pwdata[PRE_W-1:0];
                REG_ON_TIME_MS:     on_time_ms_reg     <= pwdata[PERIOD_W-1:0];
                REG_OFF_TIME_MS:    off_time_ms_reg    <= pwdata[PERIOD_W-1:0];
                REG_WIDTH_START:    width_start_reg    <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_MIN:      width_min_reg      <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_MAX:      width_max_reg      <= pwdata[WIDTH_W-1:0];
                REG_NONE: begin
                end
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_TARGET_CURRENT: prdata = {22'd0, target_current_reg};
            REG_TICKS_PER_MS:   prdata = {27'd0, ticks_per_ms_reg};
            REG_ON_TIME_MS:     prdata = {22'd0, on_time_ms_reg};
            REG_OFF_TIME_MS:    prdata = {22'd0, off_time_ms_reg};
            REG_WIDTH_START:    prdata = {24'd0, width_start_reg};
            REG_WIDTH_MIN:      prdata = {24'd0, width_min_reg};
            REG_WIDTH_MAX:      prdata = {24'd0, width_max_reg};
            REG_NONE:           prdata = '0;
        endcase
    end

    // Handshake: take a tick whenever the result register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign sample   = s_tdata[CUR_W-1:0];

    // Width step, saturating, then clamp (min check last)
    always_comb begin
        if (sample > target_current_reg) begin
            w_step = (width_reg != '0) ? width_reg - 1'b1 : width_reg;
        end else begin
            w_step = (width_reg != '1) ? width_reg + 1'b1 : width_reg;
        end
        w_clamp = (w_step > width_max_reg) ? width_max_reg : w_step;
        if (w_clamp < width_min_reg) begin
            w_clamp = width_min_reg;
        end
    end

    // Prescaler and period countdown
    assign ms_evt        = (prescale_reg == '0);
    assign pre_base      = ms_evt ? ticks_per_ms_reg : prescale_reg;
    assign prescale_next = pre_base - 1'b1;
    assign period_dec    = (period_reg != '0) ? period_reg - 1'b1 : period_reg;

    // Mode machine and width register next state
    always_comb begin
        mode_next   = mode_reg;
        active_next = active_reg;
        width_next  = active_reg ? w_clamp : width_reg;
        period_next = period_reg;
        if (ms_evt) begin
            period_next = period_dec;
            unique case (mode_reg)
                MODE_INIT: begin
                    mode_next = MODE_IDLE;
                end
                MODE_IDLE: begin
                    mode_next   = MODE_ON;
                    active_next = 1'b1;
                    width_next  = width_start_reg;
                    period_next = on_time_ms_reg;
                end
                MODE_ON: begin
                    if (period_dec == '0) begin
                        mode_next   = MODE_OFF;
                        active_next = 1'b0;
                        width_next  = width_start_reg;
                        period_next = off_time_ms_reg;
                    end
                end
                MODE_OFF: begin
                    if (period_dec == '0) begin
                        mode_next   = MODE_ON;
                        active_next = 1'b1;
                        width_next  = width_start_reg;
                        period_next = on_time_ms_reg;
                    end
                end
            endcase
        end
    end

    // Result packing
    always_comb begin
        out_data_next        = '0;
        out_data_next[0]     = active_reg;
        out_data_next[8:1]   = active_reg ? w_clamp : '0;
        out_data_next[9]     = (mode_next == MODE_ON);
        out_data_next[10]    = ms_evt;
    end

    // State registers advance once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_INIT;
            active_reg   <= 1'b0;
            width_reg    <= RST_WIDTH_START;
            prescale_reg <= '0;
            period_reg   <= '0;
        end else if (in_acc) begin
            mode_reg     <= mode_next;
            active_reg   <= active_next;
            width_reg    <= width_next;
            prescale_reg <= prescale_next;
            period_reg   <= period_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/lfcr_port_checker.sv @@
// ----------------------------------------------------------------------------
// lfcr_port_checker - port-level checks for the current regulator
// Watches the stream and APB ports of the top level over time.
// ----------------------------------------------------------------------------
module lfcr_port_checker
    import lfcr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        pready
);

    // Result register is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A width is only reported with a fired pulse
    a_width_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == '0))
        else $error("pulse width without pulse");

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A stalled result holds
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // APB side never inserts wait states
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind led_flash_current_regulator lfcr_port_checker u_lfcr_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
